// ===== hw/rtl/frame_time_window_stats_top_defines.svh =====
// Assertion helpers used by fts_stats
`ifndef FRAME_TIME_WINDOW_STATS_TOP_DEFINES_SVH
`define FRAME_TIME_WINDOW_STATS_TOP_DEFINES_SVH

// checked outside reset
`define FTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fts_pkg.sv =====
package fts_pkg;

  localparam int unsigned TPS_W        = 20;
  localparam int unsigned CNT_REG_W    = 7;
  localparam int unsigned OUT_SUM_W    = 22;
  localparam int unsigned OUT_SAMPLE_W = 16;
  localparam int unsigned RATE_W       = 28;
  localparam int unsigned RATE_FRAC    = 8;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  localparam logic [CNT_REG_W-1:0] RECENT_COUNT_RST = CNT_REG_W'(10);
  localparam logic [TPS_W-1:0]     TICKS_RST        = TPS_W'(1000);

  typedef enum logic {
    REG_RECENT_COUNT = 1'b0,
    REG_TICKS        = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_OUT
  } fts_state_e;

  typedef enum logic [1:0] {
    RATE_NOW,
    RATE_AVERAGE,
    RATE_FASTEST,
    RATE_SLOWEST
  } rate_sel_e;

  typedef struct packed {
    logic [CNT_REG_W-1:0] recent_count;
    logic [TPS_W-1:0]     ticks_per_second;
  } fts_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fts_div_stat_t;

  typedef struct packed {
    logic [OUT_SUM_W-1:0]    recent_sum;
    logic [OUT_SUM_W-1:0]    window_sum;
    logic [OUT_SAMPLE_W-1:0] window_min;
    logic [OUT_SAMPLE_W-1:0] window_max;
    logic [RATE_W-1:0]       rate_now;
    logic [RATE_W-1:0]       rate_average;
    logic [RATE_W-1:0]       rate_fastest;
    logic [RATE_W-1:0]       rate_slowest;
  } fts_result_t;

endpackage

// ===== hw/rtl/fts_if.sv =====
interface fts_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

interface fts_out_if import fts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OUT_SUM_W-1:0]    recent_sum;
  logic [OUT_SUM_W-1:0]    window_sum;
  logic [OUT_SAMPLE_W-1:0] window_min;
  logic [OUT_SAMPLE_W-1:0] window_max;
  logic [RATE_W-1:0]       rate_now;
  logic [RATE_W-1:0]       rate_average;
  logic [RATE_W-1:0]       rate_fastest;
  logic [RATE_W-1:0]       rate_slowest;

  modport source (
    output valid, output recent_sum, output window_sum, output window_min,
    output window_max, output rate_now, output rate_average, output rate_fastest,
    output rate_slowest, input ready
  );
  modport sink (
    input valid, input recent_sum, input window_sum, input window_min,
    input window_max, input rate_now, input rate_average, input rate_fastest,
    input rate_slowest, output ready
  );
endinterface

// ===== hw/rtl/frame_time_window_stats_top.sv =====
// Flow: an input transfer is written into the ring, the ring is walked, then four rates are
//   divided (NUM_W = 35 at default parameters) before the result is valid; one item in flight.
// Throughput is set by the ring walk (one read a cycle) and four passes through the shared
//   bit-serial divider; no new input is taken until the result of the last one is loaded.
// Reset: asynchronous, active low; a clearing pass then writes ones into all
//   WINDOW_DEPTH ring entries, one a cycle, before the first input is taken.
module frame_time_window_stats_top import fts_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fts_in_if.sink                in_i,
  fts_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW     = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + AW;
  localparam int unsigned NUM_W  = TPS_W + CNT_W + RATE_FRAC;

  fts_cfg_t          cfg;
  fts_div_stat_t     div_stat;
  fts_result_t       res;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [SUM_W-1:0]  div_den;
  logic [RATE_W-1:0] div_quot;

  assign pready = 1'b1;

  fts_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  fts_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  fts_stats #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_elapsed_i (in_i.elapsed_ms),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_res_o    (res),
    .cfg_i        (cfg),
    .div_start_o  (div_start),
    .div_num_o    (div_num),
    .div_den_o    (div_den),
    .div_stat_i   (div_stat),
    .div_quot_i   (div_quot)
  );

  assign out_o.recent_sum   = res.recent_sum;
  assign out_o.window_sum   = res.window_sum;
  assign out_o.window_min   = res.window_min;
  assign out_o.window_max   = res.window_max;
  assign out_o.rate_now     = res.rate_now;
  assign out_o.rate_average = res.rate_average;
  assign out_o.rate_fastest = res.rate_fastest;
  assign out_o.rate_slowest = res.rate_slowest;

endmodule

// ===== hw/rtl/fts_cfg.sv =====
module fts_cfg import fts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output fts_cfg_t              cfg_o
);

  logic [CNT_REG_W-1:0] count_q;
  logic [TPS_W-1:0]     tps_q;
  logic                 wr_en;
  reg_idx_e             reg_idx;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = reg_idx_e'(paddr_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= RECENT_COUNT_RST;
      tps_q   <= TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RECENT_COUNT: count_q <= pwdata_i[CNT_REG_W-1:0];
        REG_TICKS:        tps_q   <= pwdata_i[TPS_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RECENT_COUNT: prdata_o = APB_DATA_W'(count_q);
      REG_TICKS:        prdata_o = APB_DATA_W'(tps_q);
      default:          prdata_o = '0;
    endcase
  end

  assign cfg_o.recent_count     = count_q;
  assign cfg_o.ticks_per_second = tps_q;

endmodule

// ===== hw/rtl/fts_div.sv =====
module fts_div import fts_pkg::*; #(
  parameter int unsigned NUM_W = 35,
  parameter int unsigned DEN_W = 22,
  localparam int unsigned CW   = $clog2(NUM_W + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output fts_div_stat_t     stat_o,
  output logic [RATE_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [RATE_W-1:0] quot_q;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [DEN_W-1:0]  rem_d;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[RATE_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ===== hw/rtl/fts_stats.sv =====
`include "frame_time_window_stats_top_defines.svh"

module fts_stats import fts_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS  = 16,
  localparam int unsigned AW     = $clog2(WINDOW_DEPTH),
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned SUM_W  = SAMPLE_BITS + AW,
  localparam int unsigned PROD_W = TPS_W + CNT_W,
  localparam int unsigned NUM_W  = PROD_W + RATE_FRAC
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] in_elapsed_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output fts_result_t            out_res_o,
  input  fts_cfg_t               cfg_i,
  output logic                   div_start_o,
  output logic [NUM_W-1:0]       div_num_o,
  output logic [SUM_W-1:0]       div_den_o,
  input  fts_div_stat_t          div_stat_i,
  input  logic [RATE_W-1:0]      div_quot_i
);

  localparam int unsigned CMP_W = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
  localparam logic [AW-1:0]    LAST_IDX  = AW'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

  fts_state_e             state_q, state_d;
  rate_sel_e              sel_q, sel_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [CNT_W-1:0]       walk_q, walk_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [AW-1:0]          rd_idx_q;
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [SUM_W-1:0]       recent_q, recent_d;
  logic [SUM_W-1:0]       total_q, total_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [SUM_W-1:0]       den_q, den_d;
  logic [RATE_W-1:0]      rate_q [4];
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  fts_result_t            res_q;

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  logic [CMP_W-1:0]       rc_ext;
  logic [CNT_W-1:0]       count_eff;
  logic [PROD_W-1:0]      factor;
  logic [PROD_W-1:0]      prod;
  logic                   in_fire;

  // recent count: zero reads as one, above the depth saturates
  assign rc_ext = CMP_W'(cfg_i.recent_count);
  always_comb begin
    if (rc_ext == '0) begin
      count_eff = CNT_W'(1);
    end else if (rc_ext > CMP_W'(WINDOW_DEPTH)) begin
      count_eff = DEPTH_CNT;
    end else begin
      count_eff = CNT_W'(rc_ext);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  // ring storage
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign mem_waddr = (state_q == ST_CLEAR) ? pos_q : wp_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? SAMPLE_BITS'(1) : sample_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= ring_mem[pos_q];
    rd_idx_q  <= walk_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sel_q       <= RATE_NOW;
      wp_q        <= '0;
      pos_q       <= '0;
      walk_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      wp_q        <= wp_d;
      pos_q       <= pos_d;
      walk_q      <= walk_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    recent_q <= recent_d;
    total_q  <= total_d;
    min_q    <= min_d;
    max_q    <= max_d;
    num_q    <= num_d;
    den_q    <= den_d;
    if ((state_q == ST_WAIT) && div_stat_i.done) begin
      rate_q[sel_q] <= div_quot_i;
    end
    if (out_load) begin
      res_q.recent_sum   <= OUT_SUM_W'(recent_q);
      res_q.window_sum   <= OUT_SUM_W'(total_q);
      res_q.window_min   <= OUT_SAMPLE_W'(min_q);
      res_q.window_max   <= OUT_SAMPLE_W'(max_q);
      res_q.rate_now     <= rate_q[RATE_NOW];
      res_q.rate_average <= rate_q[RATE_AVERAGE];
      res_q.rate_fastest <= rate_q[RATE_FASTEST];
      res_q.rate_slowest <= rate_q[RATE_SLOWEST];
    end
  end

  // per-rate numerator factor and divisor
  always_comb begin
    unique case (sel_q)
      RATE_NOW: begin
        factor = PROD_W'(count_eff);
        den_d  = recent_q;
      end
      RATE_AVERAGE: begin
        factor = PROD_W'(DEPTH_CNT);
        den_d  = total_q;
      end
      RATE_FASTEST: begin
        factor = PROD_W'(1);
        den_d  = SUM_W'(min_q);
      end
      RATE_SLOWEST: begin
        factor = PROD_W'(1);
        den_d  = SUM_W'(max_q);
      end
      default: begin
        factor = '0;
        den_d  = '0;
      end
    endcase
  end

  assign prod = PROD_W'(cfg_i.ticks_per_second) * factor;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    wp_d        = wp_q;
    pos_d       = pos_q;
    walk_d      = walk_q;
    rd_vld_d    = 1'b0;
    sample_d    = sample_q;
    recent_d    = recent_q;
    total_d     = total_q;
    min_d       = min_q;
    max_d       = max_q;
    num_d       = num_q;
    div_start_o = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      ST_CLEAR: begin
        pos_d = pos_q + AW'(1);
        if (pos_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          sample_d = (in_elapsed_i == '0) ? SAMPLE_BITS'(1) : in_elapsed_i;
          wp_d     = (wp_q == LAST_IDX) ? '0 : wp_q + AW'(1);
          state_d  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        pos_d    = wp_q;
        walk_d   = '0;
        recent_d = '0;
        total_d  = '0;
        min_d    = '1;
        max_d    = '0;
        state_d  = ST_WALK;
      end
      ST_WALK: begin
        // walk backwards from the newest entry; read data is registered and arrives in the next cycle
        if (walk_q < DEPTH_CNT) begin
          rd_vld_d = 1'b1;
          walk_d   = walk_q + CNT_W'(1);
          pos_d    = (pos_q == '0) ? LAST_IDX : pos_q - AW'(1);
        end
        if (rd_vld_q) begin
          total_d = total_q + SUM_W'(rd_data_q);
          if (CNT_W'(rd_idx_q) < count_eff) begin
            recent_d = recent_q + SUM_W'(rd_data_q);
          end
          if (rd_data_q < min_q) begin
            min_d = rd_data_q;
          end
          if (rd_data_q > max_q) begin
            max_d = rd_data_q;
          end
          if (rd_idx_q == LAST_IDX) begin
            sel_d   = RATE_NOW;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        num_d   = {prod, {RATE_FRAC{1'b0}}};
        state_d = ST_START;
      end
      ST_START: begin
        div_start_o = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat_i.done) begin
          unique case (sel_q)
            RATE_NOW:     sel_d = RATE_AVERAGE;
            RATE_AVERAGE: sel_d = RATE_FASTEST;
            RATE_FASTEST: sel_d = RATE_SLOWEST;
            RATE_SLOWEST: sel_d = RATE_NOW;
            default:      sel_d = RATE_NOW;
          endcase
          state_d = (sel_q == RATE_SLOWEST) ? ST_OUT : ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign div_num_o   = num_q;
  assign div_den_o   = den_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  `FTS_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_OUT, "result raised outside output step")
  `FTS_ASSERT(a_div_idle_start, clk_i, rst_ni, div_start_o |-> !div_stat_i.busy, "divider restarted while busy")
  `FTS_ASSERT(a_min_le_max, clk_i, rst_ni, (state_q == ST_LOAD && sel_q == RATE_NOW) |-> min_q <= max_q, "window minimum above maximum")
  `FTS_ASSERT_ALWAYS(a_wp_range, clk_i, wp_q <= LAST_IDX, "write pointer beyond ring")

endmodule
